FILE: rtl/core/rdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter package
// Shared widths, defaults, command and status bundles for the converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int DIGIT_DEPTH_DEF = 32;
   localparam int VALUE_BITS_DEF  = 31;

   localparam int RADIX_W   = 4;
   localparam int DIGIT_W   = 4;
   localparam int CHUNK_BITS = 8;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic divide;
      logic pop;
   } rdc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic chunk_last;
      logic quot_zero;
      logic stack_empty;
   } rdc_sts_type;

   function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] raw);
      logic [RADIX_W-1:0] res;
      res = raw;
      if (raw < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (raw > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/rdc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter channels
// Valid/ready channels for input values, output digits and the radix register.
// ----------------------------------------------------------------------------
interface rdc_req_if #(
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rdc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rdc_pkg::DIGIT_W-1:0]  digit;
   logic                         last;
   logic                         zero_input;

   modport source (output valid, output digit, output last, output zero_input, input ready);
   modport sink   (input valid, input digit, input last, input zero_input, output ready);
endinterface

interface rdc_csr_if;
   logic                         valid;
   logic                         ready;
   logic [rdc_pkg::RADIX_W-1:0]  radix;

   modport source (output valid, output radix, input ready);
   modport sink   (input valid, input radix, output ready);
endinterface

FILE: rtl/core/rdc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter datapath
// Chunked long division by the radix, digit stack memory and output register.
// ----------------------------------------------------------------------------
module rdc_datapath #(
   parameter int DIGIT_DEPTH = rdc_pkg::DIGIT_DEPTH_DEF,
   parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [VALUE_BITS-1:0]         req_value,
   input  logic                          csr_write,
   input  logic [rdc_pkg::RADIX_W-1:0]   csr_radix,
   input  rdc_pkg::rdc_cmd_type          cmd,
   output rdc_pkg::rdc_sts_type          sts,
   output logic [rdc_pkg::DIGIT_W-1:0]   rsp_digit,
   output logic                          rsp_last,
   output logic                          rsp_zero_input
);
   import rdc_pkg::*;

   localparam int NCHUNK = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int WPAD   = NCHUNK * CHUNK_BITS;
   localparam int CW     = $clog2(NCHUNK + 1);
   localparam int AW     = $clog2(DIGIT_DEPTH);
   localparam int SW     = $clog2(DIGIT_DEPTH + 1);

   logic [RADIX_W-1:0]   radix_ff, radix_in;
   logic [WPAD-1:0]      work_ff, work_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [CW-1:0]        chunk_ff, chunk_in;
   logic [SW-1:0]        count_ff, count_in;
   logic                 zero_ff, zero_in;
   logic                 last_ff, last_in;
   logic [DIGIT_W-1:0]   rd_ff;
   logic [DIGIT_W-1:0]   stack_mem [DIGIT_DEPTH];

   logic [CHUNK_BITS-1:0] chunk_bits;
   logic [CHUNK_BITS-1:0] quot_bits;
   logic [DIGIT_W-1:0]    rem_next;
   logic [WPAD-1:0]       work_shift;
   logic [WPAD-1:0]       work_div;
   logic                  chunk_last;
   logic                  push_en;
   logic [AW-1:0]         push_addr;
   logic [AW-1:0]         pop_addr;

   // One chunk of restoring division: the partial remainder stays below the
   // radix, so every step works on five bits only.
   always_comb begin
      logic [DIGIT_W:0] part;
      chunk_bits = work_ff[WPAD-1 -: CHUNK_BITS];
      part       = {1'b0, rem_ff};
      quot_bits  = '0;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         part = {part[DIGIT_W-1:0], chunk_bits[i]};
         if (part >= {1'b0, radix_ff}) begin
            part         = part - {1'b0, radix_ff};
            quot_bits[i] = 1'b1;
         end
      end
      rem_next = part[DIGIT_W-1:0];
   end

   assign work_shift = work_ff << CHUNK_BITS;
   assign work_div   = work_shift | WPAD'(quot_bits);
   assign chunk_last = (chunk_ff == CW'(NCHUNK - 1));
   assign push_en    = cmd.divide && chunk_last && (count_ff < SW'(DIGIT_DEPTH));
   assign push_addr  = count_ff[AW-1:0];
   assign pop_addr   = AW'(count_ff - SW'(1));

   always_comb begin
      radix_in = radix_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      chunk_in = chunk_ff;
      count_in = count_ff;
      zero_in  = zero_ff;
      last_in  = last_ff;
      if (csr_write) begin
         radix_in = sat_radix(csr_radix);
      end
      if (cmd.load) begin
         work_in  = WPAD'(req_value);
         rem_in   = '0;
         chunk_in = '0;
         count_in = '0;
         zero_in  = (req_value == '0);
      end else if (cmd.divide) begin
         work_in = work_div;
         if (chunk_last) begin
            rem_in   = '0;
            chunk_in = '0;
            if (push_en) begin
               count_in = count_ff + SW'(1);
            end
         end else begin
            rem_in   = rem_next;
            chunk_in = chunk_ff + CW'(1);
         end
      end else if (cmd.pop) begin
         count_in = count_ff - SW'(1);
         last_in  = (count_ff == SW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         chunk_ff <= '0;
         count_ff <= '0;
      end else begin
         radix_ff <= radix_in;
         chunk_ff <= chunk_in;
         count_ff <= count_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      zero_ff <= zero_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[push_addr] <= rem_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rd_ff <= stack_mem[pop_addr];
      end
   end

   assign sts.chunk_last  = chunk_last;
   assign sts.quot_zero   = (work_div == '0);
   assign sts.stack_empty = (count_ff == '0);

   assign rsp_digit      = rd_ff;
   assign rsp_last       = last_ff;
   assign rsp_zero_input = zero_ff;

endmodule

FILE: rtl/core/rdc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter controller
// Sequences load, division, stack pops and the output handshake.
// ----------------------------------------------------------------------------
module rdc_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rdc_pkg::rdc_cmd_type  cmd,
   input  rdc_pkg::rdc_sts_type  sts
);
   import rdc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_POP  = 4'b0100,
      ST_SHOW = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd.load   = 1'b0;
      cmd.divide = 1'b0;
      cmd.pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.divide = 1'b1;
            // The value is fully converted once a digit leaves a zero quotient.
            if (sts.chunk_last && sts.quot_zero) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = sts.stack_empty ? ST_IDLE : ST_POP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/radix_digit_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter
// Converts a non-negative integer to digits in base 2 to 10, most significant
// digit first.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                       Handshake
//  req_bus   in         value                         valid/ready
//  rsp_bus   out        digit, last, zero_input       valid/ready
//  csr_bus   in         radix (saturated to 2..10)    valid/ready, always ready
//
//  Division works on the value in chunks of 8 bits, 8 quotient bits per
//  cycle, and a zero input still runs one digit.
//  Reset is synchronous and active high; the radix returns to 10.
//  A stalled result holds its digit; no new value is taken until the last
//  digit of the current one has been accepted.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
   parameter int DIGIT_DEPTH = rdc_pkg::DIGIT_DEPTH_DEF,
   parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rdc_req_if.sink    req_bus,
   rdc_rsp_if.source  rsp_bus,
   rdc_csr_if.sink    csr_bus
);
   import rdc_pkg::*;

   rdc_cmd_type cmd;
   rdc_sts_type sts;

   assign csr_bus.ready = 1'b1;

   rdc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rdc_datapath #(
      .DIGIT_DEPTH (DIGIT_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_bus.value),
      .csr_write      (csr_bus.valid),
      .csr_radix      (csr_bus.radix),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_digit      (rsp_bus.digit),
      .rsp_last       (rsp_bus.last),
      .rsp_zero_input (rsp_bus.zero_input)
   );

endmodule

FILE: rtl/core/rdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter checker
// Port-level assertions on the converter, attached by bind.
// ----------------------------------------------------------------------------
module rdc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rdc_pkg::DIGIT_W-1:0]   rsp_digit,
   input logic                          rsp_last,
   input logic                          rsp_zero_input
);
   import rdc_pkg::*;

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit)
         && $stable(rsp_last) && $stable(rsp_zero_input))
      else $error("rsp item changed while stalled");

   // One value at a time: no input is taken while a digit is on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a digit is pending");

   // An accepted item starts conversion, so input closes at once.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an accepted item");

   // A zero input gives one final digit of zero.
   a_zero_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_input |-> rsp_last && (rsp_digit == '0))
      else $error("malformed zero result");

   // After the final digit is taken the block is free again.
   a_free_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("block not idle after final digit");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_digit      (rsp_bus.digit),
   .rsp_last       (rsp_bus.last),
   .rsp_zero_input (rsp_bus.zero_input)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter testbench
// Feeds integers through the converter under a range of radix settings and
// checks every digit, last flag and zero flag. The expected digits come from
// an in-bench division model. Both handshakes are throttled at random, and one
// long hold on the result side backs up the input channel.
// ----------------------------------------------------------------------------
module testbench;
   import rdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 200;
   localparam int PHASE_VALUES   = 16;

   typedef logic [VALUE_BITS_DEF-1:0] value_type;
   typedef logic [RADIX_W-1:0]        radix_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last;
      logic               zero_input;
   } digit_item_type;

   // Predicts the digit sequence for each accepted value and checks the
   // results against it in order.
   class digit_scoreboard;
      digit_item_type expected_digits[$];
      radix_type      radix_reg;
      int             errors;
      int             values_seen;
      int             zero_seen;
      int             digits_seen;

      function new();
         radix_reg   = RADIX_RESET;
         errors      = 0;
         values_seen = 0;
         zero_seen   = 0;
         digits_seen = 0;
      endfunction

      // Register codes outside 2..10 clamp to the nearest legal base.
      function int unsigned base_of();
         if (radix_reg < 2) begin
            return 2;
         end
         if (radix_reg > 10) begin
            return 10;
         end
         return radix_reg;
      endfunction

      function int pending();
         return expected_digits.size();
      endfunction

      function void note_value(value_type value);
         logic [DIGIT_W-1:0] low_first[$];
         value_type          rest;
         int unsigned        b;
         b = base_of();
         rest = value;
         values_seen++;
         if (rest == '0) begin
            zero_seen++;
            expected_digits.push_back('{digit: '0, last: 1'b1, zero_input: 1'b1});
            return;
         end
         while (rest != '0) begin
            low_first.push_back(DIGIT_W'(rest % b));
            rest = value_type'(rest / b);
         end
         // A full stack loses the most significant digits.
         if (low_first.size() > DIGIT_DEPTH_DEF) begin
            low_first = low_first[0:DIGIT_DEPTH_DEF-1];
         end
         for (int i = low_first.size() - 1; i >= 0; i--) begin
            expected_digits.push_back('{digit: low_first[i], last: (i == 0),
                                        zero_input: 1'b0});
         end
      endfunction

      function void check_digit(logic [DIGIT_W-1:0] digit, logic last, logic zero_input);
         digit_item_type want;
         digits_seen++;
         if (expected_digits.size() == 0) begin
            errors++;
            $display("%0t: unexpected item digit=%0d last=%0b zero_input=%0b, expected none",
                     $time, digit, last, zero_input);
            return;
         end
         want = expected_digits.pop_front();
         if (want.digit !== digit) begin
            errors++;
            $display("%0t: digit mismatch, expected %0d, actual %0d", $time, want.digit, digit);
         end
         if (want.last !== last) begin
            errors++;
            $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last);
         end
         if (want.zero_input !== zero_input) begin
            errors++;
            $display("%0t: zero_input mismatch, expected %0b, actual %0b",
                     $time, want.zero_input, zero_input);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   rdc_req_if #(.VALUE_BITS(VALUE_BITS_DEF)) req_bus ();
   rdc_rsp_if                                rsp_bus ();
   rdc_csr_if                                csr_bus ();

   radix_digit_converter i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   digit_scoreboard sb = new();

   bit req_no_idle = 1'b0;
   bit rsp_no_idle = 1'b0;
   bit hold_rsp    = 1'b0;
   bit hold_taken  = 1'b0;
   int radix_writes = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Leaves valid high when the next item follows with no gap.
   task automatic send_value(input value_type value);
      int gap;
      gap = req_no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_value(value);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_radix(input radix_type radix);
      csr_bus.valid <= 1'b1;
      csr_bus.radix <= radix;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.radix_reg = radix;
      radix_writes++;
   endtask

   task automatic change_radix(input radix_type radix);
      drain_results();
      write_radix(radix);
   endtask

   // Mix of zeros, short values, powers of the base and their neighbors,
   // near-full values and random values of random length.
   function automatic value_type random_value();
      logic [63:0] power;
      int unsigned b;
      int          top_exp;
      int          k;
      int          pick;
      b = sb.base_of();
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            return '0;
         end
         1, 2: begin
            return value_type'($urandom_range(1, b * b * b));
         end
         3, 4: begin
            power = 1;
            top_exp = 0;
            while (power * b < 64'h8000_0000) begin
               power = power * b;
               top_exp++;
            end
            k = $urandom_range(1, top_exp);
            power = 1;
            repeat (k) power = power * b;
            return value_type'($urandom_range(0, 1) ? power : power - 1);
         end
         5: begin
            return value_type'({VALUE_BITS_DEF{1'b1}} - $urandom_range(0, 15));
         end
         default: begin
            return value_type'($urandom() >> $urandom_range(0, 30));
         end
      endcase
   endfunction

   initial begin
      value_type at_ten[$];
      value_type at_two[$];
      radix_type phases[$];
      at_ten = '{0, 1, 9, 10, 99, 31'h7FFF_FFFF, 31'h4000_0000,
                 31'h2AAA_AAAA, 31'h5555_5555, 1000000000};
      at_two = '{0, 1, 2, 31'h7FFF_FFFF, 31'h4000_0000};
      phases = '{3, 4, 5, 6, 7, 8, 9, 12, 2, 14, 10, 15};
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.radix <= RADIX_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed values: the reset base first, then base 2, then the clamped codes.
      foreach (at_ten[i]) send_value(at_ten[i]);
      change_radix(2);
      foreach (at_two[i]) send_value(at_two[i]);
      change_radix(0);
      send_value(6);
      change_radix(15);
      send_value(123456789);
      change_radix(1);
      send_value(2);
      change_radix(11);
      send_value(10);

      foreach (phases[p]) begin
         change_radix(phases[p]);
         req_no_idle = ($urandom_range(0, 3) == 0) || (p == 4);
         rsp_no_idle = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_VALUES; n++) begin
            // Stall the result side while values keep coming.
            if (p == 4 && n == 6) begin
               hold_rsp = 1'b1;
            end
            send_value(random_value());
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Converted %0d values (%0d zero) over %0d radix writes, clamped codes included.",
               sb.values_seen, sb.zero_seen, radix_writes);
      $display("Checked %0d digits with %0d mismatches and %0d still outstanding.",
               sb.digits_seen, sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[radix_digit_converter] OK");
      end else begin
         $display("[radix_digit_converter] ERROR");
      end
      $finish;
   end

   // Result side: check each accepted item, then maybe hold off a while.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_digit(rsp_bus.digit, rsp_bus.last, rsp_bus.zero_input);
            stall_left = rsp_no_idle ? 0 : pick_gap();
         end
         if (hold_rsp && !hold_taken) begin
            stall_left = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: no handshake for %0d cycles, %0d digits outstanding",
               $time, WATCHDOG_LIMIT, sb.pending());
      $display("[radix_digit_converter] ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/rdc_pkg.sv
rtl/core/rdc_if.sv
rtl/core/rdc_datapath.sv
rtl/core/rdc_controller.sv
rtl/core/radix_digit_converter.sv
rtl/core/rdc_checker.sv
test/testbench.sv
